// ----- design/sha256_hash_engine_top_defines.svh -----
// assertion macros for the sha-256 hash engine
// expects clk_i and rst_ni in the scope of the user
`ifndef SHA256_HASH_ENGINE_TOP_DEFINES_SVH
`define SHA256_HASH_ENGINE_TOP_DEFINES_SVH

// same cycle implication
`define SHA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next cycle implication
`define SHA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/sha256_pkg.sv -----
// types, constants and round functions of the sha-256 hash engine
// no dependencies
package sha256_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_COMP,
    ST_ADD,
    ST_OUT
  } state_e;

  typedef logic [31:0] word_t;

  localparam logic [7:0] PadByte  = 8'h80;
  localparam logic [5:0] LenStart = 6'd56;
  localparam logic [5:0] LastSlot = 6'd63;
  localparam logic [2:0] LastWord = 3'd7;

  localparam word_t InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic word_t round_k(input logic [5:0] idx);
    word_t k;
    k = 32'h0;
    case (idx)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  function automatic word_t big_sigma0(input word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

// ----- design/sha256_hash_engine_top.sv -----
// sha-256 hash engine: byte buffer, shared round unit and sequencer
// depends on sha256_pkg and sha256_hash_engine_top_defines.svh
//
// An absorb item shifts one byte into the block. The 64th byte of a block
// starts 64 rounds through the single round unit, then the ST_ADD state
// folds the working words into the chaining words. A finish item pads the
// block (one byte a cycle into the block shift register), compresses it,
// pads and compresses one more block when more than 55 bytes were held,
// and then puts out the eight digest words. No byte is absorbed while
// busy_o is high. The digest leaves as eight consecutive words, each marked
// by strobe_o, with last_word_o on the eighth; the receiver cannot hold
// them off, so it must take one word every cycle. busy_o is high
// from the acceptance of a finish item, or of a block-completing byte, until
// the work is done.
`include "sha256_hash_engine_top_defines.svh"

module sha256_hash_engine_top import sha256_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        func_i,
  input  logic [7:0]  data_byte_i,
  output logic        busy_o,
  output logic        strobe_o,
  output logic [31:0] digest_word_o,
  output logic        last_word_o
);

  state_e      state_q, state_d;
  logic [5:0]  fill_q, fill_d;
  logic [60:0] total_q, total_d;
  logic [5:0]  rnd_q, rnd_d;
  logic        pad_act_q, pad_act_d;
  logic        pad_first_q, pad_first_d;
  logic        final_q, final_d;
  word_t       h_q [8];
  word_t       v_q [8];
  word_t       w_q [16];

  logic        accept, absorb, finish;
  logic        shift_en, load_v, out_done;
  logic [63:0] len_shift;
  logic [7:0]  pad_byte, in_byte;
  word_t       t1, t2, w_new, ch, maj;

  assign accept   = start_i && !busy_o;
  assign absorb   = accept && !func_i;
  assign finish   = accept && func_i;
  assign shift_en = absorb || (state_q == ST_PAD);
  assign load_v   = (state_d == ST_COMP) && (state_q != ST_COMP);
  assign out_done = (state_q == ST_OUT) && (rnd_q[2:0] == LastWord);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (absorb && fill_q == LastSlot) begin
          state_d = ST_COMP;
        end else if (finish) begin
          state_d = ST_PAD;
        end
      end
      ST_PAD: begin
        if (fill_q == LastSlot) state_d = ST_COMP;
      end
      ST_COMP: begin
        if (rnd_q == LastSlot) state_d = ST_ADD;
      end
      ST_ADD: begin
        if (!pad_act_q) begin
          state_d = ST_IDLE;
        end else if (final_q) begin
          state_d = ST_OUT;
        end else begin
          state_d = ST_PAD;
        end
      end
      ST_OUT: begin
        if (rnd_q[2:0] == LastWord) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy_o        = (state_q != ST_IDLE);
    strobe_o      = (state_q == ST_OUT);
    digest_word_o = h_q[rnd_q[2:0]];
    last_word_o   = (state_q == ST_OUT) && (rnd_q[2:0] == LastWord);
  end

  // padding byte source
  always_comb begin
    len_shift = {total_q, 3'b000} << {fill_q[2:0], 3'b000};
    if (pad_first_q) begin
      pad_byte = PadByte;
    end else if (final_q && fill_q >= LenStart) begin
      pad_byte = len_shift[63:56];
    end else begin
      pad_byte = 8'h00;
    end
    in_byte = (state_q == ST_PAD) ? pad_byte : data_byte_i;
  end

  // round unit and schedule expansion
  always_comb begin
    ch    = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    maj   = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t1    = v_q[7] + big_sigma1(v_q[4]) + ch + round_k(rnd_q) + w_q[0];
    t2    = big_sigma0(v_q[0]) + maj;
    w_new = small_sigma1(w_q[14]) + w_q[9] + small_sigma0(w_q[1]) + w_q[0];
  end

  // control next values
  always_comb begin
    fill_d      = fill_q;
    total_d     = total_q;
    pad_act_d   = pad_act_q;
    pad_first_d = pad_first_q;
    final_d     = final_q;
    if (shift_en) fill_d = fill_q + 6'd1;
    if (absorb) total_d = total_q + 61'd1;
    if (finish) begin
      pad_act_d   = 1'b1;
      pad_first_d = 1'b1;
      final_d     = (fill_q < LenStart);
    end
    if (state_q == ST_PAD) pad_first_d = 1'b0;
    if (state_q == ST_ADD && pad_act_q) final_d = 1'b1;
    if (out_done) begin
      fill_d    = '0;
      total_d   = '0;
      pad_act_d = 1'b0;
      final_d   = 1'b0;
    end
    if ((state_q == ST_COMP || state_q == ST_OUT) && state_d == state_q) begin
      rnd_d = rnd_q + 6'd1;
    end else begin
      rnd_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      total_q     <= '0;
      rnd_q       <= '0;
      pad_act_q   <= 1'b0;
      pad_first_q <= 1'b0;
      final_q     <= 1'b0;
      h_q         <= InitHash;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      total_q     <= total_d;
      rnd_q       <= rnd_d;
      pad_act_q   <= pad_act_d;
      pad_first_q <= pad_first_d;
      final_q     <= final_d;
      if (state_q == ST_ADD) begin
        for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
      end else if (out_done) begin
        h_q <= InitHash;
      end
    end
  end

  // block shift register, doubles as rolling schedule
  always_ff @(posedge clk_i) begin
    if (shift_en) begin
      for (int i = 0; i < 15; i++) w_q[i] <= {w_q[i][23:0], w_q[i+1][31:24]};
      w_q[15] <= {w_q[15][23:0], in_byte};
    end else if (state_q == ST_COMP) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= w_new;
    end
  end

  // working words
  always_ff @(posedge clk_i) begin
    if (load_v) begin
      v_q <= h_q;
    end else if (state_q == ST_COMP) begin
      v_q[0] <= t1 + t2;
      v_q[1] <= v_q[0];
      v_q[2] <= v_q[1];
      v_q[3] <= v_q[2];
      v_q[4] <= v_q[3] + t1;
      v_q[5] <= v_q[4];
      v_q[6] <= v_q[5];
      v_q[7] <= v_q[6];
    end
  end

  `SHA_ASSERT_IMP(a_last_strobe, last_word_o, strobe_o, "last word without strobe")
  `SHA_ASSERT_NXT(a_words_run, strobe_o && !last_word_o, strobe_o, "digest words broken up")
  `SHA_ASSERT_NXT(a_restart, strobe_o && last_word_o,
                  !busy_o && total_q == '0 && fill_q == '0 && h_q[0] == InitHash[0],
                  "engine not back to initial state after digest")
  `SHA_ASSERT_NXT(a_block_full, absorb && fill_q == LastSlot, state_q == ST_COMP,
                  "full block not compressed")
  `SHA_ASSERT_NXT(a_round_end, state_q == ST_COMP && rnd_q == LastSlot, state_q == ST_ADD,
                  "compression did not end after last round")

endmodule
